FILE: rtl/ala_pkg.sv
package ala_pkg;

   localparam int ISQ_STEPS  = 32;
   localparam int CDIV_STEPS = 35;
   localparam int QDIV_STEPS = 55;
   localparam int NUM_CH     = 3;

   // item position counts: front end, root, setup, cosine, products, colour divide
   localparam int VLD_LEN = 2 + ISQ_STEPS + 1 + CDIV_STEPS + 2 + QDIV_STEPS;
   localparam int DEN_DLY = CDIV_STEPS - 2;
   localparam int SIDE_DLY = CDIV_STEPS;

   typedef logic [2:0]  csr_index_type;
   typedef logic [63:0] den_type;
   typedef logic [82:0] prod_type;
   typedef logic [54:0] quo_type;

   localparam csr_index_type CSR_NORMAL  = 3'd0;
   localparam csr_index_type CSR_COLOR   = 3'd1;
   localparam csr_index_type CSR_AREA    = 3'd2;
   localparam csr_index_type CSR_ATT_C   = 3'd3;
   localparam csr_index_type CSR_ATT_L   = 3'd4;
   localparam csr_index_type CSR_ATT_Q   = 3'd5;

endpackage

FILE: rtl/ala_isqrt.sv
module ala_isqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] radicand,
   output logic [31:0] root
);

   logic [33:0] rem_ff  [ala_pkg::ISQ_STEPS];
   logic [31:0] root_ff [ala_pkg::ISQ_STEPS];
   logic [63:0] val_ff  [ala_pkg::ISQ_STEPS];

   for (genvar k = 0; k < ala_pkg::ISQ_STEPS; k++) begin : g_step
      logic [33:0] rem_prev;
      logic [31:0] root_prev;
      logic [63:0] val_prev;
      logic [35:0] rem_sh;
      logic [35:0] trial;
      logic        ge;
      logic [33:0] rem_in;
      logic [31:0] root_in;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign val_prev  = radicand;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign val_prev  = val_ff[k-1];
      end

      assign rem_sh  = {rem_prev, val_prev[63:62]};
      assign trial   = {2'b00, root_prev, 2'b01};
      assign ge      = rem_sh >= trial;
      assign rem_in  = ge ? 34'(rem_sh - trial) : rem_sh[33:0];
      assign root_in = {root_prev[30:0], ge};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            val_ff[k]  <= {val_prev[61:0], 2'b00};
         end
      end
   end

   assign root = root_ff[ala_pkg::ISQ_STEPS-1];

endmodule

FILE: rtl/ala_cdiv.sv
module ala_cdiv (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] num,
   input  logic [31:0] dvsr,
   output logic [34:0] quot
);

   logic [31:0] rem_ff  [ala_pkg::CDIV_STEPS];
   logic [34:0] bits_ff [ala_pkg::CDIV_STEPS];
   logic [31:0] dvsr_ff [ala_pkg::CDIV_STEPS];

   for (genvar k = 0; k < ala_pkg::CDIV_STEPS; k++) begin : g_step
      logic [31:0] rem_prev;
      logic [34:0] bits_prev;
      logic [31:0] dvsr_prev;
      logic [32:0] rem_sh;
      logic        ge;
      logic [31:0] rem_in;

      if (k == 0) begin : g_first
         assign rem_prev  = {3'b000, num[63:35]};
         assign bits_prev = num[34:0];
         assign dvsr_prev = dvsr;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign bits_prev = bits_ff[k-1];
         assign dvsr_prev = dvsr_ff[k-1];
      end

      assign rem_sh = {rem_prev, bits_prev[34]};
      assign ge     = rem_sh >= {1'b0, dvsr_prev};
      assign rem_in = ge ? 32'(rem_sh - {1'b0, dvsr_prev}) : rem_sh[31:0];

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            bits_ff[k] <= {bits_prev[33:0], ge};
            dvsr_ff[k] <= dvsr_prev;
         end
      end
   end

   assign quot = bits_ff[ala_pkg::CDIV_STEPS-1];

endmodule

FILE: rtl/ala_qdiv.sv
module ala_qdiv (
   input  logic                clock,
   input  logic                en,
   input  ala_pkg::prod_type   num  [ala_pkg::NUM_CH],
   input  ala_pkg::den_type    den,
   output ala_pkg::quo_type    quot [ala_pkg::NUM_CH]
);

   ala_pkg::den_type rem_ff  [ala_pkg::QDIV_STEPS][ala_pkg::NUM_CH];
   ala_pkg::quo_type bits_ff [ala_pkg::QDIV_STEPS][ala_pkg::NUM_CH];
   ala_pkg::den_type den_ff  [ala_pkg::QDIV_STEPS];

   for (genvar k = 0; k < ala_pkg::QDIV_STEPS; k++) begin : g_step
      ala_pkg::den_type den_prev;

      if (k == 0) begin : g_dfirst
         assign den_prev = den;
      end else begin : g_dnext
         assign den_prev = den_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k] <= den_prev;
         end
      end

      for (genvar c = 0; c < ala_pkg::NUM_CH; c++) begin : g_ch
         ala_pkg::den_type rem_prev;
         ala_pkg::quo_type bits_prev;
         logic [64:0]      rem_sh;
         logic             ge;
         ala_pkg::den_type rem_in;

         if (k == 0) begin : g_first
            assign rem_prev  = {36'd0, num[c][82:55]};
            assign bits_prev = num[c][54:0];
         end else begin : g_next
            assign rem_prev  = rem_ff[k-1][c];
            assign bits_prev = bits_ff[k-1][c];
         end

         assign rem_sh = {rem_prev, bits_prev[54]};
         assign ge     = rem_sh >= {1'b0, den_prev};
         assign rem_in = ge ? 64'(rem_sh - {1'b0, den_prev}) : rem_sh[63:0];

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k][c]  <= rem_in;
               bits_ff[k][c] <= {bits_prev[53:0], ge};
            end
         end
      end
   end

   for (genvar c = 0; c < ala_pkg::NUM_CH; c++) begin : g_out
      assign quot[c] = bits_ff[ala_pkg::QDIV_STEPS-1][c];
   end

endmodule

FILE: rtl/area_light_attenuation_top.sv
// area light attenuation, fully pipelined
// req channel: one direction item (dir_x, dir_y, dir_z, signed Q16.16) per
// handshake; rsp channel: red, green, blue (signed Q16.16, saturated) in
// rsp_tdata and the error flag in rsp_tuser, one result item per request item,
// in order.
// csr channel: register index and data, always ready, taken at once; write
// only while no item is in flight.
// from request handshake to rsp_tvalid an item passes 2 front-end stages,
// 32 square-root steps (one root bit each), 1 setup stage, 35 cosine divide
// steps, 2 product stages, 55 colour divide steps (one quotient bit each,
// three channels side by side) and the output register.
// throughput is one item per cycle while the receiver takes results; every
// stage is a register row under a common advance enable.
// when the receiver holds rsp_tready low with a result shown, the whole
// pipeline freezes and req_tready drops until the result is taken; nothing
// is lost or repeated.
// reset empties the pipeline and loads the register defaults (constant
// attenuation 1.0, all others zero).
module area_light_attenuation_top (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // dir_x, dir_y, dir_z

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // red, green, blue
   output logic        rsp_tuser,   // error

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data
);

   logic        en;
   logic [47:0] normal_ff;
   logic [47:0] color_ff;
   logic [31:0] area_ff;
   logic [31:0] att_c_ff;
   logic [31:0] att_l_ff;
   logic [31:0] att_q_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_ff <= '0;
         color_ff  <= '0;
         area_ff   <= '0;
         att_c_ff  <= 32'h0001_0000;
         att_l_ff  <= '0;
         att_q_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            ala_pkg::CSR_NORMAL: normal_ff <= csr_data;
            ala_pkg::CSR_COLOR:  color_ff  <= csr_data;
            ala_pkg::CSR_AREA:   area_ff   <= csr_data[31:0];
            ala_pkg::CSR_ATT_C:  att_c_ff  <= csr_data[31:0];
            ala_pkg::CSR_ATT_L:  att_l_ff  <= csr_data[31:0];
            ala_pkg::CSR_ATT_Q:  att_q_ff  <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // colour times area, config only
   logic [47:0] tcol_ff [ala_pkg::NUM_CH];
   always_ff @(posedge clock) begin
      for (int c = 0; c < ala_pkg::NUM_CH; c++) begin
         tcol_ff[c] <= color_ff[16*c +: 16] * area_ff;
      end
   end

   // valid chain and pipeline advance
   logic vld_ff [ala_pkg::VLD_LEN];
   logic rsp_valid_ff;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ala_pkg::VLD_LEN; i++) vld_ff[i] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < ala_pkg::VLD_LEN; i++) vld_ff[i] <= vld_ff[i-1];
         rsp_valid_ff <= vld_ff[ala_pkg::VLD_LEN-1];
      end
   end

   // squares, dot partials and their sums
   logic signed [31:0] dx, dy, dz;
   logic [31:0] ax, ay, az;
   logic [63:0] sqx_ff, sqy_ff, sqz_ff;
   logic signed [47:0] px_ff, py_ff, pz_ff;
   logic [63:0] s_ff;
   logic signed [49:0] dot_ff;

   assign dx = req_tdata[31:0];
   assign dy = req_tdata[63:32];
   assign dz = req_tdata[95:64];
   assign ax = dx[31] ? 32'(-dx) : dx;
   assign ay = dy[31] ? 32'(-dy) : dy;
   assign az = dz[31] ? 32'(-dz) : dz;

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff <= ax * ax;
         sqy_ff <= ay * ay;
         sqz_ff <= az * az;
         px_ff  <= $signed(normal_ff[15:0])  * dx;
         py_ff  <= $signed(normal_ff[31:16]) * dy;
         pz_ff  <= $signed(normal_ff[47:32]) * dz;
         s_ff   <= sqx_ff + sqy_ff + sqz_ff;
         dot_ff <= 50'(px_ff) + 50'(py_ff) + 50'(pz_ff);
      end
   end

   logic [31:0] root;
   ala_isqrt u_isqrt (
      .clock    (clock),
      .en       (en),
      .radicand (s_ff),
      .root     (root)
   );

   logic [63:0]        s_dl   [ala_pkg::ISQ_STEPS];
   logic signed [49:0] dot_dl [ala_pkg::ISQ_STEPS];
   always_ff @(posedge clock) begin
      if (en) begin
         s_dl[0]   <= s_ff;
         dot_dl[0] <= dot_ff;
         for (int i = 1; i < ala_pkg::ISQ_STEPS; i++) begin
            s_dl[i]   <= s_dl[i-1];
            dot_dl[i] <= dot_dl[i-1];
         end
      end
   end

   // setup: cosine numerator and divisor, attenuation products, sign and zero flags
   logic [63:0]        s_d;
   logic signed [49:0] dot_d;
   logic [47:0]        sq_d;
   logic [49:0]        dmag;
   logic [63:0] cnum_ff;
   logic [31:0] d_ff;
   logic [63:0] lin_ff;
   logic [55:0] qlo_ff, qhi_ff;
   logic        neg_ff, zero_ff;

   assign s_d   = s_dl[ala_pkg::ISQ_STEPS-1];
   assign dot_d = dot_dl[ala_pkg::ISQ_STEPS-1];
   assign sq_d  = s_d[63:16];
   assign dmag  = dot_d[49] ? 50'(-dot_d) : dot_d;

   always_ff @(posedge clock) begin
      if (en) begin
         cnum_ff <= {dmag[47:0], 16'd0};
         d_ff    <= root;
         lin_ff  <= att_l_ff * root;
         qlo_ff  <= att_q_ff * sq_d[23:0];
         qhi_ff  <= att_q_ff * sq_d[47:24];
         neg_ff  <= !dot_d[49] && (dot_d != '0);
         zero_ff <= s_d == '0;
      end
   end

   logic [34:0] cosmag;
   ala_cdiv u_cdiv (
      .clock (clock),
      .en    (en),
      .num   (cnum_ff),
      .dvsr  (d_ff),
      .quot  (cosmag)
   );

   // denominator
   logic [79:0]      qsum;
   logic [63:0]      quad_ff;
   logic [48:0]      base_ff;
   logic [64:0]      dsum;
   ala_pkg::den_type den_ff;
   ala_pkg::den_type den_dl [ala_pkg::DEN_DLY];

   assign qsum = {24'd0, qlo_ff} + {qhi_ff, 24'd0};
   assign dsum = {16'd0, base_ff} + {1'b0, quad_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         quad_ff <= qsum[79:16];
         base_ff <= {17'd0, att_c_ff} + {1'b0, lin_ff[63:16]};
         den_ff  <= dsum[64] ? '1 : dsum[63:0];
         den_dl[0] <= den_ff;
         for (int i = 1; i < ala_pkg::DEN_DLY; i++) den_dl[i] <= den_dl[i-1];
      end
   end

   logic neg_dl  [ala_pkg::SIDE_DLY];
   logic zero_dl [ala_pkg::SIDE_DLY];
   always_ff @(posedge clock) begin
      if (en) begin
         neg_dl[0]  <= neg_ff;
         zero_dl[0] <= zero_ff;
         for (int i = 1; i < ala_pkg::SIDE_DLY; i++) begin
            neg_dl[i]  <= neg_dl[i-1];
            zero_dl[i] <= zero_dl[i-1];
         end
      end
   end

   // colour products
   logic [58:0]      plo_ff [ala_pkg::NUM_CH];
   logic [58:0]      phi_ff [ala_pkg::NUM_CH];
   ala_pkg::den_type den_c_ff;
   logic             neg_c_ff, zero_c_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < ala_pkg::NUM_CH; c++) begin
            plo_ff[c] <= tcol_ff[c][23:0]  * cosmag;
            phi_ff[c] <= tcol_ff[c][47:24] * cosmag;
         end
         den_c_ff  <= den_dl[ala_pkg::DEN_DLY-1];
         neg_c_ff  <= neg_dl[ala_pkg::SIDE_DLY-1];
         zero_c_ff <= zero_dl[ala_pkg::SIDE_DLY-1];
      end
   end

   ala_pkg::prod_type num_in [ala_pkg::NUM_CH];
   ala_pkg::prod_type num_ff [ala_pkg::NUM_CH];
   logic              ovf_in [ala_pkg::NUM_CH];
   ala_pkg::den_type  den_q_ff;
   logic              neg_q_ff, err_q_ff;
   logic              ovf_q_ff [ala_pkg::NUM_CH];

   always_comb begin
      for (int c = 0; c < ala_pkg::NUM_CH; c++) begin
         num_in[c] = {24'd0, plo_ff[c]} + {phi_ff[c], 24'd0};
         ovf_in[c] = {36'd0, num_in[c][82:55]} >= den_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < ala_pkg::NUM_CH; c++) begin
            num_ff[c]   <= num_in[c];
            ovf_q_ff[c] <= ovf_in[c];
         end
         den_q_ff <= den_c_ff;
         neg_q_ff <= neg_c_ff;
         err_q_ff <= zero_c_ff || (den_c_ff == '0);
      end
   end

   ala_pkg::quo_type quot [ala_pkg::NUM_CH];
   ala_qdiv u_qdiv (
      .clock (clock),
      .en    (en),
      .num   (num_ff),
      .den   (den_q_ff),
      .quot  (quot)
   );

   logic neg_o_dl [ala_pkg::QDIV_STEPS];
   logic err_o_dl [ala_pkg::QDIV_STEPS];
   logic ovf_o_dl [ala_pkg::QDIV_STEPS][ala_pkg::NUM_CH];
   always_ff @(posedge clock) begin
      if (en) begin
         neg_o_dl[0] <= neg_q_ff;
         err_o_dl[0] <= err_q_ff;
         for (int c = 0; c < ala_pkg::NUM_CH; c++) ovf_o_dl[0][c] <= ovf_q_ff[c];
         for (int i = 1; i < ala_pkg::QDIV_STEPS; i++) begin
            neg_o_dl[i] <= neg_o_dl[i-1];
            err_o_dl[i] <= err_o_dl[i-1];
            for (int c = 0; c < ala_pkg::NUM_CH; c++) ovf_o_dl[i][c] <= ovf_o_dl[i-1][c];
         end
      end
   end

   // saturate, sign and output register
   logic        neg_o, err_o;
   logic [31:0] chan_in [ala_pkg::NUM_CH];
   logic [95:0] rsp_data_ff;
   logic        rsp_err_ff;

   assign neg_o = neg_o_dl[ala_pkg::QDIV_STEPS-1];
   assign err_o = err_o_dl[ala_pkg::QDIV_STEPS-1];

   always_comb begin
      for (int c = 0; c < ala_pkg::NUM_CH; c++) begin
         logic [32:0] mag;
         logic        ovf;
         mag = quot[c][54:22];
         ovf = ovf_o_dl[ala_pkg::QDIV_STEPS-1][c];
         if (err_o) begin
            chan_in[c] = '0;
         end else if (neg_o) begin
            chan_in[c] = (ovf || mag > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(-mag);
         end else begin
            chan_in[c] = (ovf || mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= {chan_in[2], chan_in[1], chan_in[0]};
         rsp_err_ff  <= err_o;
      end
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_err_ff;

`ifndef SYNTHESIS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("error item carries nonzero colour");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      en && !vld_ff[ala_pkg::VLD_LEN-1] |=> !rsp_tvalid)
      else $error("result without an item in the last stage");
`endif

endmodule

FILE: verif/area_light_checker.sv
module area_light_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [95:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data,
   output int          pending,
   output int          fail_count,
   output int          shade_count,
   output int          error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        error;
      logic [31:0] blue;
      logic [31:0] green;
      logic [31:0] red;
   } shade_type;

   logic [47:0] light_normal;
   logic [47:0] light_color;
   logic [31:0] area_per_sample;
   logic [31:0] c0, c1, c2;
   shade_type   expected_shades[$];

   function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic shade_type shade(logic [95:0] dir);
      shade_type   s;
      longint      dx, dy, dz, nx, ny, nz, dot;
      logic [63:0] sumsq, dlen, dmag, cosmag, sq, lin, quad, t, sh;
      logic [64:0] acc;
      logic [127:0] wide, quo;
      logic [31:0] r;
      logic        neg;
      s = '0;
      dx = longint'(signed'(dir[31:0]));
      dy = longint'(signed'(dir[63:32]));
      dz = longint'(signed'(dir[95:64]));
      nx = longint'(signed'(light_normal[15:0]));
      ny = longint'(signed'(light_normal[31:16]));
      nz = longint'(signed'(light_normal[47:32]));
      sumsq = 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
      if (sumsq == 0) begin
         s.error = 1'b1;
         return s;
      end
      dlen = root_floor(sumsq);
      dot = nx * dx + ny * dy + nz * dz;
      neg = dot > 0;
      dmag = dot < 0 ? 64'(-dot) : 64'(dot);
      cosmag = (dmag << 16) / dlen;
      sq = sumsq >> 16;
      lin = (64'(c1) * dlen) >> 16;
      wide = (128'(c2) * 128'(sq)) >> 16;
      quad = wide[127:64] != 0 ? '1 : wide[63:0];
      acc = 65'(c0) + 65'(lin);
      if (acc[64]) acc = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
      acc = 65'(acc[63:0]) + 65'(quad);
      if (acc[64]) acc = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
      if (acc[63:0] == 0) begin
         s.error = 1'b1;
         return s;
      end
      for (int c = 0; c < 3; c++) begin
         t = 64'(light_color[16*c +: 16]) * 64'(area_per_sample);
         quo = (128'(t) * 128'(cosmag)) / 128'(acc[63:0]);
         quo = quo >> 22;
         sh = quo[63:0];
         if (neg) begin
            r = (quo[127:64] != 0 || sh > 64'h8000_0000) ? 32'h8000_0000 : sh[31:0];
            r = -r;
         end else begin
            r = (quo[127:64] != 0 || sh > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : sh[31:0];
         end
         case (c)
            0: s.red = r;
            1: s.green = r;
            default: s.blue = r;
         endcase
      end
      return s;
   endfunction

   assign pending = expected_shades.size();

   always @(posedge clock) begin
      shade_type want, got;
      if (reset) begin
         light_normal <= '0;
         light_color <= '0;
         area_per_sample <= '0;
         c0 <= 32'd65536;
         c1 <= '0;
         c2 <= '0;
         expected_shades.delete();
         fail_count <= 0;
         shade_count <= 0;
         error_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ala_pkg::CSR_NORMAL: light_normal <= csr_data;
               ala_pkg::CSR_COLOR:  light_color <= csr_data;
               ala_pkg::CSR_AREA:   area_per_sample <= csr_data[31:0];
               ala_pkg::CSR_ATT_C:  c0 <= csr_data[31:0];
               ala_pkg::CSR_ATT_L:  c1 <= csr_data[31:0];
               ala_pkg::CSR_ATT_Q:  c2 <= csr_data[31:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_shades.push_back(shade(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata};
            shade_count <= shade_count + 1;
            if (rsp_tuser) error_count <= error_count + 1;
            if (expected_shades.size() == 0) begin
               $error("unexpected result item %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_shades.pop_front();
               if (got != want) begin
                  fail_count <= fail_count + 1;
                  if (got.red != want.red)
                     $error("red: expected %h, got %h", want.red, got.red);
                  if (got.green != want.green)
                     $error("green: expected %h, got %h", want.green, got.green);
                  if (got.blue != want.blue)
                     $error("blue: expected %h, got %h", want.blue, got.blue);
                  if (got.error != want.error)
                     $error("error: expected %b, got %b", want.error, got.error);
               end
            end
         end
      end
   end

endmodule

FILE: verif/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [47:0] csr_data = '0;
   int          pending, fail_count, shade_count, error_count;
   int          cycles = 0;
   int          burst_left = 0;
   int          stall_mode = 0;
   int          config_writes = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   area_light_attenuation_top dut (.*);

   area_light_checker checker_i (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver stall pattern, changes character every so often
   always @(posedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= $urandom_range(0, 3) != 0;
         2: rsp_tready <= $urandom_range(0, 1) == 1;
         default: rsp_tready <= (cycles % 16) < 5;
      endcase
   end

   task automatic send_dir(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
         if (gap > 0 && req_tvalid) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {dz, dy, dx};
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic drain();
      if (req_tvalid) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(ala_pkg::csr_index_type idx, logic [47:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
      config_writes++;
      @(posedge clock);
   endtask

   task automatic load_light(logic [47:0] n, logic [47:0] col, logic [31:0] area,
                             logic [31:0] k0, logic [31:0] k1, logic [31:0] k2);
      drain();
      write_reg(ala_pkg::CSR_NORMAL, n);
      write_reg(ala_pkg::CSR_COLOR, col);
      write_reg(ala_pkg::CSR_AREA, {16'd0, area});
      write_reg(ala_pkg::CSR_ATT_C, {16'd0, k0});
      write_reg(ala_pkg::CSR_ATT_L, {16'd0, k1});
      write_reg(ala_pkg::CSR_ATT_Q, {16'd0, k2});
      // unused indexes must be ignored
      write_reg(ala_pkg::csr_index_type'(ala_pkg::CSR_ATT_Q + 1 + $urandom_range(0, 1)),
                48'({$urandom, $urandom}));
   endtask

   function automatic logic [31:0] rand_comp(int kind);
      case (kind)
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
         2: return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
         default: return $urandom_range(0, 3) - 1;
      endcase
   endfunction

   function automatic logic [31:0] rand_coeff();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(0, 32'h0004_0000);
      endcase
   endfunction

   function automatic logic [15:0] rand_normal_comp();
      if ($urandom_range(0, 3) == 0) return 16'($urandom);
      return 16'($signed($urandom_range(0, 32'h8000)) - 32'sh4000);
   endfunction

   initial begin
      int kind;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: light facing -z, unit colour, no falloff
      load_light({16'hC000, 16'h0000, 16'h0000}, {16'h0100, 16'h0100, 16'h0100},
                 32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0);
      send_dir(32'd0, 32'd0, 32'd0);
      send_dir(32'd0, 32'd0, 32'h0001_0000);
      send_dir(32'd0, 32'd0, 32'hFFFF_0000);
      send_dir(32'h0001_0000, 32'd0, 32'd0);
      send_dir(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_dir(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_dir(32'd1, 32'd0, 32'd0);
      send_dir(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // saturation both signs, non-unit normal
      load_light({16'h7FFF, 16'h8000, 16'h7FFF}, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                 32'd1, 32'd0, 32'd0);
      send_dir(32'h0000_0100, 32'h0000_0100, 32'h0000_0100);
      send_dir(32'hFFFF_FF00, 32'hFFFF_FF00, 32'hFFFF_FF00);
      send_dir(32'h8000_0000, 32'd0, 32'h7FFF_FFFF);
      send_dir(32'd0, 32'h7FFF_FFFF, 32'd0);
      send_dir(32'd0, 32'd0, 32'd0);
      // zero denominator, and one that only truncates to zero
      load_light({16'h0000, 16'h4000, 16'h0000}, 48'h0123_4567_89AB, 32'h0002_0000,
                 32'd0, 32'd0, 32'd0);
      send_dir(32'd0, 32'h0001_0000, 32'd0);
      send_dir(32'h7FFF_FFFF, 32'h8000_0000, 32'd5);
      load_light({16'h0000, 16'h4000, 16'h0000}, 48'h0123_4567_89AB, 32'h0002_0000,
                 32'd0, 32'd1, 32'd1);
      send_dir(32'd1, 32'd0, 32'd0);
      send_dir(32'd0, 32'h0001_0000, 32'd0);
      send_dir(32'd0, 32'hFFFF_0000, 32'd0);
      // huge coefficients saturate the denominator
      load_light({16'h4000, 16'h4000, 16'h4000}, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_dir(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_dir(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_dir(32'h0000_8000, 32'd0, 32'd0);

      for (int phase = 0; phase < 6; phase++) begin
         load_light({rand_normal_comp(), rand_normal_comp(), rand_normal_comp()},
                    48'({$urandom, $urandom}), rand_coeff(), rand_coeff(), rand_coeff(),
                    rand_coeff());
         kind = $urandom_range(0, 3);
         for (int i = 0; i < 64; i++) begin
            if ($urandom_range(0, 49) == 0)
               send_dir(32'd0, 32'd0, 32'd0);
            else if ($urandom_range(0, 2) == 0)
               send_dir(rand_comp($urandom_range(0, 3)), rand_comp($urandom_range(0, 3)),
                        rand_comp($urandom_range(0, 3)));
            else
               send_dir(rand_comp(kind), rand_comp(kind), rand_comp(kind));
         end
      end

      // back to all-zero light
      load_light('0, '0, 32'd0, 32'd0, 32'd0, 32'd0);
      for (int i = 0; i < 16; i++) send_dir($urandom, $urandom, $urandom);

      drain();
      repeat (200) @(posedge clock);
      $display("%0d result items checked (%0d flagged), %0d register writes, %0d cycles",
               shade_count, error_count, config_writes, cycles);
      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/ala_pkg.sv
rtl/ala_isqrt.sv
rtl/ala_cdiv.sv
rtl/ala_qdiv.sv
rtl/area_light_attenuation_top.sv
verif/area_light_checker.sv
verif/testbench.sv
